@@ rtl/core/nptr_pkg.sv @@
// nptr_pkg: shared constants and types for the nested-to-ring coordinate converter.
// No dependencies; imported by nptr_unpack, nptr_ring and the top level.

package nptr_pkg;

   localparam int NPTR_MAX_ORDER = 13;
   localparam int ORDER_W        = 4;
   localparam int PIXEL_W        = 30;
   localparam int RING_W         = 15;
   localparam int POS_W          = 16;
   localparam int COORD_W        = 13;
   localparam int FACE_COUNT     = 12;
   localparam int NTHETA         = 3;
   localparam int NPHI           = 4;
   localparam int ARITH_W        = 17;
   localparam int NUM_W          = 20;

   typedef struct packed {
      logic                 oor;
      logic [1:0]           frow;
      logic [1:0]           fcol;
      logic [ORDER_W-1:0]   order;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
   } unpack_type;

endpackage

@@ rtl/core/nptr_unpack.sv @@
// nptr_unpack: splits a nested pixel number into face row/column and de-interleaved x/y.
// Depends on nptr_pkg.

module nptr_unpack #(
   parameter int MAX_ORDER = nptr_pkg::NPTR_MAX_ORDER
) (
   input  logic [nptr_pkg::PIXEL_W-1:0] pixel,
   input  logic [nptr_pkg::ORDER_W-1:0] order,
   output nptr_pkg::unpack_type         fields
);
   import nptr_pkg::*;

   logic [ORDER_W-1:0] order_eff;
   logic [ORDER_W:0]   shift;
   logic [PIXEL_W-1:0] face_full;

   assign order_eff = (order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order;
   assign shift     = {order_eff, 1'b0};
   assign face_full = pixel >> shift;

   always_comb begin
      fields       = '0;
      fields.oor   = (face_full >= PIXEL_W'(FACE_COUNT));
      fields.frow  = face_full[3:2];
      fields.fcol  = face_full[1:0];
      fields.order = order_eff;
      for (int k = 0; k < COORD_W; k++) begin
         if (k < int'(order_eff)) begin
            fields.x[k] = pixel[2*k];
            fields.y[k] = pixel[2*k+1];
         end
      end
   end

endmodule

@@ rtl/core/nptr_ring.sv @@
// nptr_ring: ring number and in-ring position from face row/column and x/y.
// Depends on nptr_pkg.

module nptr_ring (
   input  nptr_pkg::unpack_type        fields,
   output logic [nptr_pkg::RING_W-1:0] ring_number,
   output logic [nptr_pkg::POS_W-1:0]  position_in_ring,
   output logic                        out_of_range
);
   import nptr_pkg::*;

   logic [ARITH_W-1:0]      nside;
   logic [2:0]              base;
   logic [ARITH_W-1:0]      base_side;
   logic [ARITH_W-1:0]      vv;
   logic [ARITH_W-1:0]      ring;
   logic                    north;
   logic                    south;
   logic [ARITH_W-1:0]      nr;
   logic [3:0]              phase;
   logic [NUM_W-2:0]        prod;
   logic signed [COORD_W+1:0] h2;
   logic                    inc;
   logic signed [NUM_W-1:0] num;
   logic signed [NUM_W-1:0] pos;
   logic signed [NUM_W-1:0] posm1;
   logic [ARITH_W-1:0]      len_mask;
   logic [ARITH_W-1:0]      wrapped;
   logic [ARITH_W-1:0]      pos_final;

   assign nside     = ARITH_W'(1) << fields.order;
   assign base      = {1'b0, fields.frow} + 3'd2;
   assign base_side = ARITH_W'(base) << fields.order;
   assign vv        = ARITH_W'(fields.x) + ARITH_W'(fields.y);
   assign ring      = base_side - vv - ARITH_W'(1);

   // north cap below nside, south cap from 3*nside up
   assign north = (ring < nside);
   assign south = (ring >= ARITH_W'(NTHETA) * nside);
   assign nr    = north ? ring : (south ? (ARITH_W'(NTHETA + 1) * nside - ring) : nside);

   assign phase = {1'b0, fields.fcol, 1'b0} - {3'b000, fields.frow[0]} + 4'd1;
   assign prod  = (NUM_W-1)'(phase) * (NUM_W-1)'(nr);
   assign h2    = $signed({2'b00, fields.x}) - $signed({2'b00, fields.y});
   assign inc   = (north || south) ? 1'b1 : ~(ring[0] ^ nside[0]);
   assign num   = $signed({1'b0, prod}) + NUM_W'(h2) + $signed({{(NUM_W-1){1'b0}}, inc});

   // division by two truncating toward zero
   assign pos   = num[NUM_W-1] ? ((num + NUM_W'(1)) >>> 1) : (num >>> 1);
   assign posm1 = pos - NUM_W'(1);

   // belt ring length is 4*nside, a power of two
   assign len_mask  = (nside << 2) - ARITH_W'(1);
   assign wrapped   = (posm1[ARITH_W-1:0] & len_mask) + ARITH_W'(1);
   assign pos_final = (north || south) ? pos[ARITH_W-1:0] : wrapped;

   assign out_of_range     = fields.oor;
   assign ring_number      = fields.oor ? '0 : ring[RING_W-1:0];
   assign position_in_ring = fields.oor ? '0 : pos_final[POS_W-1:0];

endmodule

@@ rtl/core/nested_pixel_to_ring_coords_top.sv @@
// nested_pixel_to_ring_coords_top: nested pixel number to ring number / in-ring position.
// Depends on nptr_pkg, nptr_unpack and nptr_ring.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  request | req_valid, req_ready, req_pixel_number        | in
//  result  | rsp_valid, rsp_ready, rsp_ring_number,        | out
//          | rsp_position_in_ring, rsp_out_of_range        |
//  csr     | csr_wr_en, csr_wr_data (resolution order)     | in
//
// Two register stages: input register, then result register. One request per cycle
// is sustained while rsp_ready stays high; the math between the stages is shifts, one
// 4x17 multiply and adds. Synchronous reset clears valids and the order register.
// A stalled result holds in the result register while one more request waits in
// the input register.

module nested_pixel_to_ring_coords_top #(
   parameter int MAX_ORDER = nptr_pkg::NPTR_MAX_ORDER
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [nptr_pkg::PIXEL_W-1:0] req_pixel_number,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [nptr_pkg::RING_W-1:0]  rsp_ring_number,
   output logic [nptr_pkg::POS_W-1:0]   rsp_position_in_ring,
   output logic                         rsp_out_of_range,
   input  logic                         csr_wr_en,
   input  logic [nptr_pkg::ORDER_W-1:0] csr_wr_data
);
   import nptr_pkg::*;

   logic [ORDER_W-1:0] order_ff;
   logic               s1_vld_ff, s1_vld_in;
   logic [PIXEL_W-1:0] s1_pix_ff;
   logic               out_vld_ff, out_vld_in;
   logic [RING_W-1:0]  out_ring_ff;
   logic [POS_W-1:0]   out_pos_ff;
   logic               out_oor_ff;
   logic               s1_adv;
   logic               req_take;
   unpack_type         fields;
   logic [RING_W-1:0]  calc_ring;
   logic [POS_W-1:0]   calc_pos;
   logic               calc_oor;

   assign s1_adv     = s1_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready  = !s1_vld_ff || s1_adv;
   assign req_take   = req_valid && req_ready;
   assign s1_vld_in  = req_take || (s1_vld_ff && !s1_adv);
   assign out_vld_in = s1_adv || (out_vld_ff && !rsp_ready);

   nptr_unpack #(
      .MAX_ORDER(MAX_ORDER)
   ) u_unpack (
      .pixel  (s1_pix_ff),
      .order  (order_ff),
      .fields (fields)
   );

   nptr_ring u_ring (
      .fields           (fields),
      .ring_number      (calc_ring),
      .position_in_ring (calc_pos),
      .out_of_range     (calc_oor)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pix_ff <= req_pixel_number;
      end
      if (s1_adv) begin
         out_ring_ff <= calc_ring;
         out_pos_ff  <= calc_pos;
         out_oor_ff  <= calc_oor;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_ring_number      = out_ring_ff;
   assign rsp_position_in_ring = out_pos_ff;
   assign rsp_out_of_range     = out_oor_ff;

`ifndef NO_ASSERTIONS
   a_oor_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_ring_number == '0 && rsp_position_in_ring == '0))
      else $error("out-of-range result carries nonzero coordinates");

   a_valid_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_of_range) |-> (rsp_ring_number != '0 && rsp_position_in_ring != '0))
      else $error("in-range result has zero ring or position");

   a_stall_backs_up : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_vld_ff && out_vld_ff && !rsp_ready))
      else $error("request stalled without a full pipeline");

   a_drain : assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !out_vld_ff) |=> out_vld_ff)
      else $error("pending request not moved to result register");
`endif

endmodule

@@ tb/tb_nested_pixel_to_ring_coords_top.sv @@
// Self-checking testbench for nested_pixel_to_ring_coords_top: nested pixel requests
// against an in-bench ring/position predictor, under varied resolution orders and stalls.
// Depends on nptr_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_nested_pixel_to_ring_coords_top;
   import nptr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PROBE_COUNT = 25;

   typedef struct packed {
      logic [RING_W-1:0] ring;
      logic [POS_W-1:0]  pos;
      logic              oor;
   } ring_coord_type;

   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic [PIXEL_W-1:0] pixel;
      logic               typed;
      ring_coord_type     want;
   } probe_type;

   localparam ring_coord_type FLAGGED = '{ring: '0, pos: '0, oor: 1'b1};
   localparam ring_coord_type FIRST   = '{ring: 15'd1, pos: 16'd1, oor: 1'b0};
   localparam ring_coord_type NONE    = '{ring: '0, pos: '0, oor: 1'b0};

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIXEL_W-1:0]   req_pixel_number = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [RING_W-1:0]    rsp_ring_number;
   logic [POS_W-1:0]     rsp_position_in_ring;
   logic                 rsp_out_of_range;
   logic                 csr_wr_en = 1'b0;
   logic [ORDER_W-1:0]   csr_wr_data = '0;

   ring_coord_type       coords_pending[$];
   ring_coord_type       coords_head;
   logic [ORDER_W-1:0]   cur_order = '0;
   int                   src_idle_pct = 0;
   int                   sink_stall_pct = 0;
   int                   mismatches = 0;
   int                   cycles = 0;
   int                   requests_sent = 0;
   int                   results_seen = 0;
   int                   flagged_seen = 0;
   int                   order_writes = 0;

   probe_type probes [PROBE_COUNT] = '{
      '{4'd0,  30'd0,          1'b1, FIRST},
      '{4'd0,  30'd4,          1'b1, '{15'd2, 16'd4, 1'b0}},
      '{4'd0,  30'd11,         1'b1, '{15'd3, 16'd4, 1'b0}},
      '{4'd0,  30'd12,         1'b1, FLAGGED},
      '{4'd0,  30'h3FFFFFFF,   1'b1, FLAGGED},
      '{4'd0,  30'd5,          1'b0, NONE},
      '{4'd0,  30'd8,          1'b0, NONE},
      '{4'd1,  30'd0,          1'b0, NONE},
      '{4'd1,  30'd47,         1'b0, NONE},
      '{4'd1,  30'd48,         1'b1, FLAGGED},
      '{4'd1,  30'd6,          1'b0, NONE},
      '{4'd1,  30'd33,         1'b0, NONE},
      '{4'd2,  30'd10,         1'b0, NONE},
      '{4'd2,  30'd101,        1'b0, NONE},
      '{4'd2,  30'd191,        1'b0, NONE},
      '{4'd13, 30'd0,          1'b0, NONE},
      '{4'd13, 30'h03FFFFFF,   1'b1, FIRST},
      '{4'd13, 30'h2FFFFFFF,   1'b0, NONE},
      '{4'd13, 30'h30000000,   1'b1, FLAGGED},
      '{4'd13, 30'h3FFFFFFF,   1'b1, FLAGGED},
      '{4'd13, 30'h02AAAAAA,   1'b0, NONE},
      '{4'd13, 30'h01555555,   1'b0, NONE},
      '{4'd15, 30'h03FFFFFF,   1'b1, FIRST},
      '{4'd15, 30'h30000000,   1'b1, FLAGGED},
      '{4'd14, 30'h1FFFFFFF,   1'b0, NONE}
   };

   nested_pixel_to_ring_coords_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_pixel_number     (req_pixel_number),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ring_number      (rsp_ring_number),
      .rsp_position_in_ring (rsp_position_in_ring),
      .rsp_out_of_range     (rsp_out_of_range),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic ring_coord_type ring_coords(input logic [ORDER_W-1:0] ord,
                                                  input logic [PIXEL_W-1:0] pixel);
      int unsigned       eff;
      longint unsigned   face;
      longint unsigned   inner;
      longint            nside, x, y, vv, h2, frow, fcol, base, phase;
      longint            ring, nr, num, pos, len4;
      ring_coord_type    res;
      eff = (ord > NPTR_MAX_ORDER) ? NPTR_MAX_ORDER : ord;
      face = longint'(pixel) >> (2 * eff);
      inner = longint'(pixel) & ((64'd1 << (2 * eff)) - 1);
      nside = longint'(1) << eff;
      res = NONE;
      if (face >= FACE_COUNT) begin
         res.oor = 1'b1;
         return res;
      end
      x = 0;
      y = 0;
      for (int k = 0; k < eff; k++) begin
         x = x | (longint'(inner[2*k]) << k);
         y = y | (longint'(inner[2*k+1]) << k);
      end
      vv = x + y;
      h2 = x - y;
      frow = longint'(face / NPHI);
      fcol = longint'(face % NPHI);
      base = frow + 2;
      phase = 2 * fcol - (frow & 1) + 1;
      ring = base * nside - vv - 1;
      if (ring < nside) begin
         nr = ring;
         num = phase * ring + h2 + 1;
      end else if (ring > NTHETA * nside - 1) begin
         nr = (NTHETA + 1) * nside - ring;
         num = phase * nr + h2 + 1;
      end else begin
         nr = nside;
         num = phase * nside + h2 + ((ring - nside + 1) & 1);
      end
      pos = num / 2;
      len4 = 4 * nr;
      if (len4 < 1) len4 = 1;
      pos = ((pos - 1) % len4 + len4) % len4 + 1;
      res.ring = ring[RING_W-1:0];
      res.pos = pos[POS_W-1:0];
      return res;
   endfunction

   // mostly in-range faces; some all-zero/all-one/x-only/y-only offsets, some beyond 12 faces
   function automatic logic [PIXEL_W-1:0] rand_pixel(input logic [ORDER_W-1:0] ord);
      int unsigned       eff;
      int unsigned       sel;
      longint unsigned   mask, inner, face;
      logic [PIXEL_W-1:0] pixel;
      eff = (ord > NPTR_MAX_ORDER) ? NPTR_MAX_ORDER : ord;
      mask = (64'd1 << (2 * eff)) - 1;
      inner = {$urandom, $urandom} & mask;
      sel = $urandom_range(99);
      if (sel < 5) inner = 0;
      else if (sel < 10) inner = mask;
      else if (sel < 15) inner = inner & 64'h5555555555555555;
      else if (sel < 20) inner = inner & 64'hAAAAAAAAAAAAAAAA;
      if (sel >= 92) begin
         pixel = PIXEL_W'($urandom_range(32'h3FFFFFFF, 32'(FACE_COUNT) << (2 * eff)));
      end else begin
         face = $urandom_range(FACE_COUNT - 1);
         pixel = PIXEL_W'((face << (2 * eff)) | inner);
      end
      return pixel;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH @%0t: %s", $time, what);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("nested_pixel_to_ring_coords_top verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (coords_pending.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            coords_head = coords_pending.pop_front();
            if (coords_head.oor) flagged_seen++;
            if (rsp_ring_number !== coords_head.ring)
               report_mismatch($sformatf("ring_number got %0d want %0d",
                                         rsp_ring_number, coords_head.ring));
            if (rsp_position_in_ring !== coords_head.pos)
               report_mismatch($sformatf("position_in_ring got %0d want %0d",
                                         rsp_position_in_ring, coords_head.pos));
            if (rsp_out_of_range !== coords_head.oor)
               report_mismatch($sformatf("out_of_range got %0b want %0b",
                                         rsp_out_of_range, coords_head.oor));
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input ring_coord_type want);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_number <= pixel;
      do @(posedge clock); while (!req_ready);
      coords_pending.push_back(want);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (coords_pending.size() != 0) @(negedge clock);
   endtask

   task automatic set_order(input logic [ORDER_W-1:0] ord);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= ord;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_order = ord;
      order_writes++;
   endtask

   initial begin
      logic [PIXEL_W-1:0] pixel;
      logic [ORDER_W-1:0] ord;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset order first, then grouped by order
      foreach (probes[i]) begin
         if (probes[i].order != cur_order) set_order(probes[i].order);
         send_pixel(probes[i].pixel, probes[i].typed ? probes[i].want :
                    ring_coords(cur_order, probes[i].pixel));
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
            default: begin src_idle_pct = 11; sink_stall_pct = 11; end
         endcase
         for (int k = 0; k < 4; k++) begin
            case (k)
               0: ord = $urandom_range(12, 1);
               1: ord = $urandom_range(15, 13);
               2: ord = '0;
               default: ord = $urandom_range(15, 0);
            endcase
            set_order(ord);
            for (int n = 0; n < 100; n++) begin
               if (phase == 1 && k == 0 && n == 50) drain();
               pixel = rand_pixel(cur_order);
               send_pixel(pixel, ring_coords(cur_order, pixel));
            end
         end
      end

      drain();
      repeat (8) @(negedge clock);
      if (coords_pending.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", coords_pending.size()));
      $display("covered %0d requests (%0d results, %0d beyond twelve faces)",
               requests_sent, results_seen, flagged_seen);
      $display("across %0d order writes incl. 0, 13 and saturated values, four stall mixes",
               order_writes);
      if (mismatches == 0) begin
         $display("nested_pixel_to_ring_coords_top verification clean");
      end else begin
         $display("nested_pixel_to_ring_coords_top verification failed");
      end
      $finish;
   end

endmodule
